// File: design/kms_pkg.sv
`default_nettype none

package kms_pkg;

  localparam logic [1:0]  ROWS_IDLE    = 2'b11;
  localparam logic [1:0]  NO_ROW       = 2'd0;
  localparam logic [1:0]  ROW_ONE_CODE = 2'd3;
  localparam logic [1:0]  ROW_TWO_CODE = 2'd2;
  localparam logic [1:0]  FIRST_COLUMN = 2'd0;
  localparam logic [1:0]  LAST_COLUMN  = 2'd3;
  localparam logic [15:0] SETTLE_RESET = 16'd5;
  localparam logic [2:0]  COLUMN_BASE  = 3'd4;

  typedef struct packed {
    logic [1:0] row_levels;
    logic       read_request;
  } in_item_t;

  typedef struct packed {
    logic [3:0] column_drive;
    logic [4:0] key_code;
    logic       read_done;
    logic       scan_busy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  previous_rows;
    logic [1:0]  pending_row;
    logic [4:0]  stored_code;
    logic [1:0]  scan_column;
    logic [15:0] settle_count;
    logic        scan_active;
  } scan_state_t;

endpackage

`default_nettype wire

// File: design/kms_step.sv
`default_nettype none

module kms_step (
  input  wire kms_pkg::scan_state_t state_cur,
  input  wire kms_pkg::in_item_t    item,
  input  wire logic [15:0]          settle_ticks,
  output kms_pkg::scan_state_t      state_nxt,
  output kms_pkg::out_item_t        result
);

  logic [1:0]  fell;
  logic [15:0] load_value;
  logic        pressed;
  logic        done;
  logic [4:0]  found_code;

  assign fell       = state_cur.previous_rows & ~item.row_levels;
  assign load_value = (settle_ticks == 16'd0) ? 16'd1 : settle_ticks;
  assign pressed    = (item.row_levels != kms_pkg::ROWS_IDLE);
  assign found_code = 5'(kms_pkg::COLUMN_BASE - {1'b0, state_cur.scan_column})
                      + {1'b0, state_cur.pending_row, 2'b00};

  always_comb begin
    state_nxt = state_cur;
    done      = 1'b0;
    if (!state_cur.scan_active) begin
      if (fell[0]) begin
        state_nxt.pending_row = kms_pkg::ROW_ONE_CODE;
      end else if (fell[1]) begin
        state_nxt.pending_row = kms_pkg::ROW_TWO_CODE;
      end
      if (item.read_request) begin
        if (state_nxt.pending_row == kms_pkg::NO_ROW) begin
          done = 1'b1;
        end else begin
          state_nxt.scan_active  = 1'b1;
          state_nxt.scan_column  = kms_pkg::FIRST_COLUMN;
          state_nxt.settle_count = load_value;
        end
      end
    end else if (state_cur.settle_count > 16'd1) begin
      state_nxt.settle_count = state_cur.settle_count - 16'd1;
    end else begin
      if (pressed) begin
        state_nxt.stored_code = found_code;
      end
      if (pressed || state_cur.scan_column == kms_pkg::LAST_COLUMN) begin
        state_nxt.scan_active  = 1'b0;
        state_nxt.pending_row  = kms_pkg::NO_ROW;
        state_nxt.scan_column  = kms_pkg::FIRST_COLUMN;
        state_nxt.settle_count = 16'd0;
        done                   = 1'b1;
      end else begin
        state_nxt.scan_column  = state_cur.scan_column + 2'd1;
        state_nxt.settle_count = load_value;
      end
    end
    state_nxt.previous_rows = item.row_levels;
  end

  always_comb begin
    result.column_drive = state_nxt.scan_active ? ~(4'b0001 << state_nxt.scan_column) : 4'b0000;
    result.key_code     = state_nxt.stored_code;
    result.read_done    = done;
    result.scan_busy    = state_nxt.scan_active;
  end

endmodule

`default_nettype wire

// File: design/keypad_matrix_scanner_top.sv
`default_nettype none

// channel | ports                          | carries
// input   | in_valid, in_ready, in_data    | one tick: row levels and read request
// result  | out_valid, out_ready, out_data | column drive, key code, done, busy
// config  | cfg_valid, cfg_ready, cfg_data | settle_ticks, 16 bits
//
// one item per cycle sustained while the result side is ready
// the item waits in an input register, one pass of the step logic fills the result register
// synchronous active-low reset: scan idle, rows high, code 0, settle_ticks 5
// a stalled result holds the result register; the input register still takes
// a new item in the cycle the result is taken

module keypad_matrix_scanner_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire kms_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output kms_pkg::out_item_t      out_data,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);

  kms_pkg::in_item_t    in_data_r;
  logic                 in_valid_r;
  kms_pkg::out_item_t   out_data_r;
  logic                 out_valid_r;
  kms_pkg::scan_state_t state_r;
  kms_pkg::scan_state_t state_nxt;
  kms_pkg::out_item_t   result;
  logic [15:0]          settle_ticks_r;
  logic                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kms_step u_step (
    .state_cur    (state_r),
    .item         (in_data_r),
    .settle_ticks (settle_ticks_r),
    .state_nxt    (state_nxt),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
      settle_ticks_r         <= kms_pkg::SETTLE_RESET;
      state_r.previous_rows  <= kms_pkg::ROWS_IDLE;
      state_r.pending_row    <= kms_pkg::NO_ROW;
      state_r.stored_code    <= 5'd0;
      state_r.scan_column    <= kms_pkg::FIRST_COLUMN;
      state_r.settle_count   <= 16'd0;
      state_r.scan_active    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle_ticks_r <= cfg_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  a_scan_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.scan_active |-> state_r.pending_row != kms_pkg::NO_ROW)
    else $error("scan running without a pending row");

  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.scan_active |-> (state_r.settle_count == 16'd0
                              && state_r.scan_column == kms_pkg::FIRST_COLUMN))
    else $error("idle scanner holds column or count");

  a_scan_counting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.scan_active |-> state_r.settle_count != 16'd0)
    else $error("scan running with zero settle count");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("scan state changed without a transfer");

endmodule

`default_nettype wire

// File: tb/kms_checker.sv
module kms_checker
  import kms_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_item_t   in_data,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_item_t  out_data,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [15:0] cfg_data,
  output int         outstanding,
  output int         mismatches
);

  logic [15:0] settle_reg;
  logic [1:0]  last_rows;
  logic [1:0]  row_pending;
  logic [4:0]  key_store;
  logic [1:0]  column_idx;
  logic [15:0] settle_left;
  logic        scanning;

  out_item_t   results_due[$];
  out_item_t   want;
  int          bad_count;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic logic [15:0] settle_load();
    return (settle_reg == 16'd0) ? 16'd1 : settle_reg;
  endfunction

  function automatic out_item_t scan_tick(in_item_t tick);
    logic [1:0] fell;
    logic       done;
    logic       pressed;
    out_item_t  res;
    fell = last_rows & ~tick.row_levels;
    done = 1'b0;
    if (!scanning) begin
      if (fell[0]) begin
        row_pending = ROW_ONE_CODE;
      end else if (fell[1]) begin
        row_pending = ROW_TWO_CODE;
      end
      if (tick.read_request) begin
        if (row_pending == NO_ROW) begin
          done = 1'b1;
        end else begin
          scanning    = 1'b1;
          column_idx  = FIRST_COLUMN;
          settle_left = settle_load();
        end
      end
    end else if (settle_left > 16'd1) begin
      settle_left = settle_left - 16'd1;
    end else begin
      pressed = (tick.row_levels != ROWS_IDLE);
      if (pressed) begin
        key_store = 5'(COLUMN_BASE) - 5'(column_idx) + {1'b0, row_pending, 2'b00};
      end
      if (pressed || column_idx == LAST_COLUMN) begin
        scanning    = 1'b0;
        row_pending = NO_ROW;
        column_idx  = FIRST_COLUMN;
        settle_left = 16'd0;
        done        = 1'b1;
      end else begin
        column_idx  = column_idx + 2'd1;
        settle_left = settle_load();
      end
    end
    last_rows = tick.row_levels;
    res.column_drive = scanning ? ~(4'b0001 << column_idx) : 4'b0000;
    res.key_code     = key_store;
    res.read_done    = done;
    res.scan_busy    = scanning;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settle_reg  = SETTLE_RESET;
      last_rows   = ROWS_IDLE;
      row_pending = NO_ROW;
      key_store   = 5'd0;
      column_idx  = FIRST_COLUMN;
      settle_left = 16'd0;
      scanning    = 1'b0;
      results_due.delete();
      bad_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("result with none due: got %p", out_data);
          end
        end else begin
          want = results_due.pop_front();
          if (want.column_drive !== out_data.column_drive ||
              want.key_code     !== out_data.key_code ||
              want.read_done    !== out_data.read_done ||
              want.scan_busy    !== out_data.scan_busy) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("result mismatch: expected %p got %p", want, out_data);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(scan_tick(in_data));
      end
    end
    outstanding <= results_due.size();
    mismatches  <= bad_count;
  end

endmodule

// File: tb/tb.sv
module tb;
  import kms_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int outstanding;
  int mismatches;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int ready_run = 0;
  int ready_mode = 0;

  always #10 clk = ~clk;

  keypad_matrix_scanner_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kms_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // result side stalls in stretches of its own
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_run  = $urandom_range(4, 40);
    end else begin
      ready_run--;
    end
    case (ready_mode)
      0, 1: out_ready <= 1'b1;
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input logic [1:0] rows, input logic rd);
    if (gaps_on && burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_data  <= '{row_levels: rows, read_request: rd};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settle(input logic [15:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_ticks(input int count);
    logic [1:0] rows;
    for (int i = 0; i < count; i++) begin
      rows = ($urandom_range(0, 9) < 7) ? ROWS_IDLE : 2'($urandom_range(0, 3));
      send_tick(rows, $urandom_range(0, 3) == 0);
      if (i == count / 2 && $urandom_range(0, 1) == 1) begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_ticks(100);

    // directed ticks with zero settle time
    write_settle(16'd0);
    send_tick(2'b11, 1'b1);
    send_tick(2'b10, 1'b0);
    send_tick(2'b01, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b00, 1'b1);
    send_tick(2'b00, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b01, 1'b1);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b01, 1'b1);
    send_tick(2'b11, 1'b1);
    send_tick(2'b10, 1'b0);
    send_tick(2'b11, 1'b1);
    send_tick(2'b10, 1'b1);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b11, 1'b0);
    send_tick(2'b00, 1'b0);
    send_tick(2'b11, 1'b1);

    write_settle(16'd1);
    random_ticks(120);
    write_settle(16'd2);
    random_ticks(120);
    write_settle(16'd3);
    random_ticks(120);
    write_settle(16'($urandom_range(4, 8)));
    random_ticks(120);

    // long settle time, key held down until the first column is sampled
    write_settle(16'd40);
    gaps_on = 1'b0;
    send_tick(2'b11, 1'b0);
    send_tick(2'b10, 1'b1);
    for (int i = 0; i < 50; i++) begin
      send_tick(2'b10, 1'($urandom_range(0, 1)));
    end
    gaps_on = 1'b1;

    write_settle(16'd1);
    random_ticks(80);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
